>>> rtl/core/circular_deque_core_defines.svh
// ---------------------------------------------------------------------------
// circular_deque_core_defines
// Assertion macros shared by the deque checker.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CDQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg
// Types and constants of the circular deque core.
// ---------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CAP_W          = 11;
  localparam int CAP_RESET      = 1024;
  localparam int VALUE_W        = 32;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_REAR  = 2'd1,
    ACT_DEL_FRONT = 2'd2,
    ACT_DEL_REAR  = 2'd3
  } action_t;

  typedef struct packed {
    action_t                    action;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic                       ok;
    logic                       empty_res;
    logic                       full_res;
    logic signed [VALUE_W-1:0]  front_value;
    logic signed [VALUE_W-1:0]  rear_value;
  } out_item_t;

endpackage

>>> rtl/core/circular_deque_core.sv
// ---------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue of words held in a ring memory of DEPTH entries.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one action transaction: insert front, insert
//   rear, delete front or delete rear, with the value to insert.
//   out_valid/out_ready carry one result transaction per action: ok, the
//   empty and full flags and the front and rear values afterwards (all ones
//   when the deque is empty).
//   cfg_wr_en/cfg_wdata write the capacity (0 is taken as 1, values above
//   DEPTH as DEPTH) and clear the deque; write it only while idle.
// Timing:
//   An action is accepted and its memory write and two end reads go out in
//   the same cycle; the read data are registered, then moved to the output
//   register once it is free. A new action is taken only after that move,
//   as the registered ring memory reads must return both ends before the
//   next action may enter.
//   A result that waits on a stalled receiver stays in the output register
//   while the next action is accepted and its reads are held.
// Reset:
//   Synchronous, active low: the deque is empty and capacity is
//   min(1024, DEPTH). The ring memory itself is not cleared.
// ---------------------------------------------------------------------------
module circular_deque_core #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cdq_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cdq_pkg::out_item_t       out_data,
  input  logic                     cfg_wr_en,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_wdata
);
  import cdq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  // Ring memory and its registered read ports
  logic [DATA_WIDTH-1:0] ring_r [DEPTH];
  logic [DATA_WIDTH-1:0] rd_front_r, rd_rear_r;

  // Pointer and count state
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // In-flight result bookkeeping
  logic                  pend_r, pend_nxt;
  logic                  ok_r, empty_r, full_r;
  logic                  fwd_front_r, fwd_rear_r;
  logic [DATA_WIDTH-1:0] wdata_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r;

  // Action evaluation
  logic                  acc, load_out;
  logic                  ok_calc, mem_we;
  logic [PTR_W-1:0]      waddr, raddr_front, raddr_rear;
  logic [PTR_W-1:0]      head_calc, tail_calc;
  logic [CNT_W-1:0]      cnt_calc;
  logic [DATA_WIDTH-1:0] wdata;
  logic [31:0]           cfg_clamp;

  function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] p1;
    p1 = CNT_W'(p) + CNT_W'(1);
    return (p1 >= cap) ? '0 : PTR_W'(p1);
  endfunction

  function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
    return (p == '0) ? PTR_W'(cap - CNT_W'(1)) : p - PTR_W'(1);
  endfunction

  assign in_ready = !pend_r;
  assign acc      = in_valid && in_ready;
  assign load_out = pend_r && (!out_valid_r || out_ready);
  assign wdata    = DATA_WIDTH'($unsigned(in_data.value));

  // Evaluate the action against the current ends
  always_comb begin
    ok_calc   = 1'b0;
    mem_we    = 1'b0;
    waddr     = head_r;
    head_calc = head_r;
    tail_calc = tail_r;
    cnt_calc  = cnt_r;
    unique case (in_data.action)
      ACT_INS_FRONT: begin
        if (cnt_r < cap_r) begin
          ok_calc   = 1'b1;
          mem_we    = acc;
          waddr     = head_r;
          head_calc = slot_prev(head_r, cap_r);
          cnt_calc  = cnt_r + CNT_W'(1);
        end
      end
      ACT_INS_REAR: begin
        if (cnt_r < cap_r) begin
          ok_calc   = 1'b1;
          mem_we    = acc;
          tail_calc = slot_next(tail_r, cap_r);
          waddr     = tail_calc;
          cnt_calc  = cnt_r + CNT_W'(1);
        end
      end
      ACT_DEL_FRONT: begin
        if (cnt_r != '0) begin
          ok_calc   = 1'b1;
          head_calc = slot_next(head_r, cap_r);
          cnt_calc  = cnt_r - CNT_W'(1);
        end
      end
      ACT_DEL_REAR: begin
        if (cnt_r != '0) begin
          ok_calc   = 1'b1;
          tail_calc = slot_prev(tail_r, cap_r);
          cnt_calc  = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        ok_calc = 1'b0;
      end
    endcase
    raddr_front = slot_next(head_calc, cap_r);
    raddr_rear  = tail_calc;
  end

  // Clamp a written capacity into 1..DEPTH
  always_comb begin
    cfg_clamp = 32'(cfg_wdata);
    if (cfg_clamp == 32'd0) begin
      cfg_clamp = 32'd1;
    end
    if (cfg_clamp > 32'(DEPTH)) begin
      cfg_clamp = 32'(DEPTH);
    end
  end

  // Next state of capacity, pointers, count and handshake flags
  always_comb begin
    cap_nxt  = cap_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    priority if (cfg_wr_en) begin
      cap_nxt  = CNT_W'(cfg_clamp);
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end else if (acc) begin
      head_nxt = head_calc;
      tail_nxt = tail_calc;
      cnt_nxt  = cnt_calc;
    end else begin
      cnt_nxt = cnt_r;
    end

    pend_nxt = acc ? 1'b1 : (load_out ? 1'b0 : pend_r);
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CNT_W'(CAP_RST);
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_r[waddr] <= wdata;
    end
    if (acc) begin
      rd_front_r <= ring_r[raddr_front];
      rd_rear_r  <= ring_r[raddr_rear];
    end
  end

  // Hold result flags and forwarding info for the read in flight
  always_ff @(posedge clk) begin
    if (acc) begin
      ok_r        <= ok_calc;
      empty_r     <= (cnt_calc == '0);
      full_r      <= (cnt_calc >= cap_r);
      fwd_front_r <= mem_we && (waddr == raddr_front);
      fwd_rear_r  <= mem_we && (waddr == raddr_rear);
      wdata_r     <= wdata;
    end
  end

  // Output register: take the read data, forward a just-written word
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.ok        <= ok_r;
      out_data_r.empty_res <= empty_r;
      out_data_r.full_res  <= full_r;
      out_data_r.front_value <= empty_r ? '1 :
                                VALUE_W'(fwd_front_r ? wdata_r : rd_front_r);
      out_data_r.rear_value  <= empty_r ? '1 :
                                VALUE_W'(fwd_rear_r ? wdata_r : rd_rear_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/cdq_checker.sv
// ---------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque core, bound to the core module.
// ---------------------------------------------------------------------------
`include "circular_deque_core_defines.svh"

module cdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cdq_pkg::out_item_t out_data
);
  import cdq_pkg::*;

  // A stalled result holds its payload
  `CDQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // Capacity is at least one, so empty and full never coincide
  `CDQ_ASSERT_NOW(a_empty_full, clk, rst_n, out_valid, !(out_data.empty_res && out_data.full_res), "empty and full together")

  // An empty deque reports all-ones ends
  `CDQ_ASSERT_NOW(a_empty_ends, clk, rst_n, out_valid && out_data.empty_res, (out_data.front_value == '1) && (out_data.rear_value == '1), "empty result with element values")

  // One action in flight: no accept in the cycle after an accept
  `CDQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second action accepted while reads in flight")

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);
